### src/urlc_pkg.sv
// Package: codes, reset values and shared types of the ultrasonic range light controller.
package urlc_pkg;

  localparam int REQ_W   = 2;
  localparam int CAPIN_W = 16;
  localparam int RANGE_W = 15;
  localparam int THR_W   = 15;
  localparam int WORD_W  = 16;
  localparam int MODE_W  = 2;
  localparam int LVL_W   = 8;
  localparam int SCALE_W = 16;
  localparam int IDX_W   = 2;

  localparam logic [REQ_W-1:0] REQ_RISE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FALL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_PERIOD = 2'd3;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WARN = 2'd3;

  localparam logic [IDX_W-1:0] REG_NEAR  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FAR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_FLASH = 2'd2;
  localparam logic [IDX_W-1:0] REG_SCALE = 2'd3;

  localparam logic [THR_W-1:0]   NEAR_RST  = 15'd80;
  localparam logic [THR_W-1:0]   FAR_RST   = 15'd800;
  localparam logic [WORD_W-1:0]  FLASH_RST = 16'd200;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd17826;

  localparam logic [LVL_W-1:0]   LVL_OFF  = 8'd0;
  localparam logic [LVL_W-1:0]   LVL_DIM  = 8'd50;
  localparam logic [LVL_W-1:0]   LVL_FULL = 8'd255;
  localparam logic [RANGE_W-1:0] RANGE_MAX = 15'd32767;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [CAPIN_W-1:0] capture_time;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0]   near_threshold;
    logic [THR_W-1:0]   far_threshold;
    logic [WORD_W-1:0]  flash_interval_ms;
    logic [SCALE_W-1:0] distance_scale;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_value;
    logic [MODE_W-1:0]  mode;
  } range_res_t;

endpackage

### src/urlc_ifs.sv
// Interfaces: request, result and configuration channels.
interface urlc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] capture_time;

  modport source (output valid, output req_type, output capture_time, input ready);
  modport sink (input valid, input req_type, input capture_time, output ready);
endinterface

interface urlc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  light_mode;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [14:0] range_value;
  logic        range_new;
  logic        trigger_level;
  logic        capture_armed;

  modport source (output valid, output light_mode, output red, output green, output blue,
                  output range_value, output range_new, output trigger_level,
                  output capture_armed, input ready);
  modport sink (input valid, input light_mode, input red, input green, input blue,
                input range_value, input range_new, input trigger_level,
                input capture_armed, output ready);
endinterface

interface urlc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/urlc_in_stage.sv
// Input register: holds one request word until the core takes it.
module urlc_in_stage (
  input  logic            clk,
  input  logic            rst,
  urlc_req_if.sink        req,
  input  logic            take,
  output logic            item_valid,
  output urlc_pkg::item_t item
);
  import urlc_pkg::*;

  assign req.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      item.req_type     <= req.req_type;
      item.capture_time <= req.capture_time;
    end
  end
endmodule

### src/urlc_range.sv
// Range unit: echo width, scaling to 1/16 cm, saturation and mode choice.
module urlc_range #(
  parameter int CAPTURE_WIDTH = 16
) (
  input  logic [CAPTURE_WIDTH-1:0] rise,
  input  logic [CAPTURE_WIDTH-1:0] fall,
  input  urlc_pkg::cfg_t           cfg,
  output urlc_pkg::range_res_t     res
);
  import urlc_pkg::*;

  localparam int PW   = CAPTURE_WIDTH + 1;
  localparam int PROD = PW + SCALE_W;
  localparam int RW   = (PW > RANGE_W) ? PW : RANGE_W;

  logic [PW-1:0]      width;
  logic [PROD-1:0]    prod;
  logic [RW-1:0]      scaled;
  logic [RANGE_W-1:0] r;

  always_comb begin
    if (fall > rise) begin
      width = PW'(fall) - PW'(rise);
    end else begin
      width = PW'({CAPTURE_WIDTH{1'b1}}) - PW'(rise) + PW'(fall);
    end
    prod   = PROD'(width) * PROD'(cfg.distance_scale);
    scaled = RW'(prod[PROD-1:SCALE_W]);
    if (scaled > RW'(RANGE_MAX)) begin
      r = RANGE_MAX;
    end else begin
      r = scaled[RANGE_W-1:0];
    end
    res.range_value = r;
    if (r >= cfg.near_threshold && r <= cfg.far_threshold) begin
      res.mode = MODE_LOW;
    end else if (r > cfg.far_threshold) begin
      res.mode = MODE_HIGH;
    end else begin
      res.mode = MODE_WARN;
    end
  end
endmodule

### src/urlc_core.sv
// Core: state update for one request word and the result register.
module urlc_core #(
  parameter int CAPTURE_WIDTH = 16,
  parameter int MS_WIDTH      = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  urlc_pkg::item_t item,
  input  urlc_pkg::cfg_t  cfg,
  output logic            take,
  urlc_res_if.source      res
);
  import urlc_pkg::*;

  localparam int CIN_W = (CAPTURE_WIDTH < CAPIN_W) ? CAPTURE_WIDTH : CAPIN_W;
  localparam int CMP_W = (MS_WIDTH > WORD_W) ? MS_WIDTH : WORD_W;

  logic                     trigger_phase, trigger_phase_next;
  logic [MS_WIDTH-1:0]      trigger_start_ms, trigger_start_ms_next;
  logic [MS_WIDTH-1:0]      ms_count, ms_count_next;
  logic                     armed_flag, armed_flag_next;
  logic [CAPTURE_WIDTH-1:0] rise_time, rise_time_next;
  logic [RANGE_W-1:0]       range_reg, range_reg_next;
  logic [MODE_W-1:0]        mode_reg, mode_reg_next;
  logic [MS_WIDTH-1:0]      last_flash_ms, last_flash_ms_next;
  logic                     flash_phase, flash_phase_next;
  logic [LVL_W-1:0]         red_lvl, red_lvl_next;
  logic [LVL_W-1:0]         grn_lvl, grn_lvl_next;
  logic [LVL_W-1:0]         blu_lvl, blu_lvl_next;
  logic                     fresh;
  logic [CAPTURE_WIDTH-1:0] cap;
  logic [MS_WIDTH-1:0]      trig_age;
  logic [MS_WIDTH-1:0]      flash_age;
  range_res_t               meas;

  assign cap  = CAPTURE_WIDTH'(item.capture_time[CIN_W-1:0]);
  assign take = item_valid && (!res.valid || res.ready);

  urlc_range #(.CAPTURE_WIDTH(CAPTURE_WIDTH)) u_range (
    .rise(rise_time),
    .fall(cap),
    .cfg (cfg),
    .res (meas)
  );

  always_comb begin
    trigger_phase_next    = trigger_phase;
    trigger_start_ms_next = trigger_start_ms;
    ms_count_next         = ms_count;
    armed_flag_next       = armed_flag;
    rise_time_next        = rise_time;
    range_reg_next        = range_reg;
    mode_reg_next         = mode_reg;
    last_flash_ms_next    = last_flash_ms;
    flash_phase_next      = flash_phase;
    red_lvl_next          = red_lvl;
    grn_lvl_next          = grn_lvl;
    blu_lvl_next          = blu_lvl;
    fresh                 = 1'b0;
    trig_age              = ms_count - trigger_start_ms;

    case (item.req_type)
      REQ_RISE: begin
        if (armed_flag) begin
          rise_time_next = cap;
        end
      end
      REQ_FALL: begin
        if (armed_flag) begin
          fresh           = 1'b1;
          armed_flag_next = 1'b0;
          range_reg_next  = meas.range_value;
          if (meas.mode != mode_reg) begin
            mode_reg_next = meas.mode;
            case (meas.mode)
              MODE_LOW: begin
                red_lvl_next = LVL_DIM;
                grn_lvl_next = LVL_DIM;
                blu_lvl_next = LVL_DIM;
              end
              MODE_HIGH: begin
                red_lvl_next = LVL_FULL;
                grn_lvl_next = LVL_FULL;
                blu_lvl_next = LVL_FULL;
              end
              default: begin
                red_lvl_next = LVL_OFF;
                grn_lvl_next = LVL_OFF;
                blu_lvl_next = LVL_OFF;
              end
            endcase
          end
        end
      end
      REQ_TICK: begin
        ms_count_next = ms_count + MS_WIDTH'(1);
      end
      default: begin
        if (!trigger_phase) begin
          trigger_phase_next    = 1'b1;
          trigger_start_ms_next = ms_count;
        end else if (trig_age != '0) begin
          trigger_phase_next = 1'b0;
          rise_time_next     = '0;
          armed_flag_next    = 1'b1;
        end
      end
    endcase

    flash_age = ms_count_next - last_flash_ms;
    if (mode_reg_next == MODE_WARN &&
        CMP_W'(flash_age) > CMP_W'(cfg.flash_interval_ms)) begin
      red_lvl_next       = flash_phase ? LVL_FULL : LVL_OFF;
      grn_lvl_next       = LVL_OFF;
      blu_lvl_next       = LVL_OFF;
      flash_phase_next   = !flash_phase;
      last_flash_ms_next = ms_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_phase    <= 1'b0;
      trigger_start_ms <= '0;
      ms_count         <= '0;
      armed_flag       <= 1'b0;
      rise_time        <= '0;
      range_reg        <= '0;
      mode_reg         <= MODE_OFF;
      last_flash_ms    <= '0;
      flash_phase      <= 1'b0;
      red_lvl          <= LVL_OFF;
      grn_lvl          <= LVL_OFF;
      blu_lvl          <= LVL_OFF;
      res.valid        <= 1'b0;
    end else begin
      if (take) begin
        trigger_phase    <= trigger_phase_next;
        trigger_start_ms <= trigger_start_ms_next;
        ms_count         <= ms_count_next;
        armed_flag       <= armed_flag_next;
        rise_time        <= rise_time_next;
        range_reg        <= range_reg_next;
        mode_reg         <= mode_reg_next;
        last_flash_ms    <= last_flash_ms_next;
        flash_phase      <= flash_phase_next;
        red_lvl          <= red_lvl_next;
        grn_lvl          <= grn_lvl_next;
        blu_lvl          <= blu_lvl_next;
        res.valid        <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
    if (take) begin
      res.light_mode    <= mode_reg_next;
      res.red           <= red_lvl_next;
      res.green         <= grn_lvl_next;
      res.blue          <= blu_lvl_next;
      res.range_value   <= range_reg_next;
      res.range_new     <= fresh;
      res.trigger_level <= trigger_phase_next;
      res.capture_armed <= armed_flag_next;
    end
  end
endmodule

### src/ultrasonic_range_light_controller.sv
// Ultrasonic range light controller: top level with configuration registers.
//
// Takes one request word per clock while the result side accepts, and returns exactly one
// result word for it. An accepted word waits in the input register until the core takes
// it, which a stalled result register can delay; its result word is then loaded into the
// result register. The whole update, including the echo width times distance_scale
// multiply, its saturation and the threshold compares, fits in the single pass between
// those two registers, so throughput is one word per cycle whenever the result side keeps
// taking words.
// The configuration port is always ready; write registers only while the block is
// idle. There is no clearing pass after reset.
module ultrasonic_range_light_controller #(
  parameter int CAPTURE_WIDTH = 16,
  parameter int MS_WIDTH      = 16
) (
  input  logic       clk,
  input  logic       rst,
  urlc_req_if.sink   req,
  urlc_res_if.source res,
  urlc_cfg_if.sink   cfg
);
  import urlc_pkg::*;

  cfg_t  cfg_regs;
  logic  item_valid;
  item_t item;
  logic  take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.near_threshold    <= NEAR_RST;
      cfg_regs.far_threshold     <= FAR_RST;
      cfg_regs.flash_interval_ms <= FLASH_RST;
      cfg_regs.distance_scale    <= SCALE_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_NEAR:  cfg_regs.near_threshold    <= cfg.data[THR_W-1:0];
        REG_FAR:   cfg_regs.far_threshold     <= cfg.data[THR_W-1:0];
        REG_FLASH: cfg_regs.flash_interval_ms <= cfg.data;
        REG_SCALE: cfg_regs.distance_scale    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  urlc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .take      (take),
    .item_valid(item_valid),
    .item      (item)
  );

  urlc_core #(
    .CAPTURE_WIDTH(CAPTURE_WIDTH),
    .MS_WIDTH     (MS_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .cfg       (cfg_regs),
    .take      (take),
    .res       (res)
  );

`ifndef ASSERT_OFF
  a_new_disarms: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.range_new |-> !res.capture_armed)
    else $error("measurement result still shows capture armed");

  a_low_beam_color: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.light_mode == MODE_LOW |->
      res.red == LVL_DIM && res.green == LVL_DIM && res.blue == LVL_DIM)
    else $error("low beam with wrong lamp color");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> res.valid && !res.ready)
    else $error("request side stalled without result backpressure");
`endif
endmodule

### dv/tb.sv
// Testbench for the ultrasonic range light controller: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urlc_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LVL_W-1:0]   red;
    logic [LVL_W-1:0]   green;
    logic [LVL_W-1:0]   blue;
    logic [RANGE_W-1:0] range_value;
    logic               range_new;
    logic               trigger_level;
    logic               capture_armed;
  } light_word_t;

  typedef struct {
    logic [REQ_W-1:0]   rt;
    logic [CAPIN_W-1:0] ct;
    bit                 typed;
    light_word_t        want;
  } stim_row_t;

  localparam light_word_t W_IDLE  = '{MODE_OFF, LVL_OFF, LVL_OFF, LVL_OFF, 15'd0,
                                      1'b0, 1'b0, 1'b0};
  localparam light_word_t W_TRIG  = '{MODE_OFF, LVL_OFF, LVL_OFF, LVL_OFF, 15'd0,
                                      1'b0, 1'b1, 1'b0};
  localparam light_word_t W_ARMED = '{MODE_OFF, LVL_OFF, LVL_OFF, LVL_OFF, 15'd0,
                                      1'b0, 1'b0, 1'b1};
  localparam light_word_t W_FAR   = '{MODE_HIGH, LVL_FULL, LVL_FULL, LVL_FULL, 15'd17825,
                                      1'b1, 1'b0, 1'b0};
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 265;
  localparam int IDLE_PCT      = 35;
  localparam int SETTLE_CYCLES = 4;

  logic clk;
  logic rst;

  urlc_req_if req_if ();
  urlc_res_if res_if ();
  urlc_cfg_if cfg_if ();

  ultrasonic_range_light_controller u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  cfg_t                regs_m;
  bit                  trig_q;
  logic [WORD_W-1:0]   trig_start;
  logic [WORD_W-1:0]   ms_cnt;
  bit                  armed_q;
  logic [CAPIN_W-1:0]  rise_t;
  logic [RANGE_W-1:0]  range_q;
  logic [MODE_W-1:0]   mode_q;
  logic [WORD_W-1:0]   last_flash;
  bit                  flash_ph;
  logic [3*LVL_W-1:0]  lamp;

  light_word_t pending_lights[$];
  stim_row_t   dir_rows[$];
  light_word_t got_w;
  light_word_t want_w;
  int          bad_words;
  int          items_sent;
  bit          no_idle;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void enter_mode(logic [MODE_W-1:0] m);
    if (m != mode_q) begin
      mode_q = m;
      case (m)
        MODE_LOW:  lamp = {LVL_DIM, LVL_DIM, LVL_DIM};
        MODE_HIGH: lamp = {LVL_FULL, LVL_FULL, LVL_FULL};
        default:   lamp = '0;
      endcase
    end
  endfunction

  function automatic light_word_t step_lights(logic [REQ_W-1:0] rt, logic [CAPIN_W-1:0] ct);
    logic [16:0]        width;
    logic [32:0]        prod;
    logic [16:0]        r;
    logic [RANGE_W-1:0] rng;
    logic [WORD_W-1:0]  diff;
    bit                 fresh;
    light_word_t        w;
    fresh = 1'b0;
    case (rt)
      REQ_RISE: begin
        if (armed_q) rise_t = ct;
      end
      REQ_FALL: begin
        if (armed_q) begin
          if (ct > rise_t) width = {1'b0, ct} - {1'b0, rise_t};
          else width = (17'h0FFFF - {1'b0, rise_t}) + {1'b0, ct};
          prod = width * regs_m.distance_scale;
          r = prod[32:16];
          rng = (r > RANGE_MAX) ? RANGE_MAX : r[RANGE_W-1:0];
          range_q = rng;
          armed_q = 1'b0;
          fresh = 1'b1;
          if (rng >= regs_m.near_threshold && rng <= regs_m.far_threshold) begin
            enter_mode(MODE_LOW);
          end else if (rng > regs_m.far_threshold) begin
            enter_mode(MODE_HIGH);
          end else begin
            enter_mode(MODE_WARN);
          end
        end
      end
      REQ_TICK: begin
        ms_cnt = ms_cnt + 16'd1;
      end
      default: begin
        diff = ms_cnt - trig_start;
        if (!trig_q) begin
          trig_q = 1'b1;
          trig_start = ms_cnt;
        end else if (diff != 16'd0) begin
          trig_q = 1'b0;
          rise_t = '0;
          armed_q = 1'b1;
        end
      end
    endcase
    diff = ms_cnt - last_flash;
    if (mode_q == MODE_WARN && diff > regs_m.flash_interval_ms) begin
      lamp = flash_ph ? {LVL_FULL, LVL_OFF, LVL_OFF} : '0;
      flash_ph = ~flash_ph;
      last_flash = ms_cnt;
    end
    w.mode          = mode_q;
    w.red           = lamp[23:16];
    w.green         = lamp[15:8];
    w.blue          = lamp[7:0];
    w.range_value   = range_q;
    w.range_new     = fresh;
    w.trigger_level = trig_q;
    w.capture_armed = armed_q;
    return w;
  endfunction

  function automatic string show(light_word_t w);
    return $sformatf("mode=%0d rgb=%0d/%0d/%0d range=%0d new=%0b trig=%0b armed=%0b",
                     w.mode, w.red, w.green, w.blue, w.range_value, w.range_new,
                     w.trigger_level, w.capture_armed);
  endfunction

  task automatic send_item(logic [REQ_W-1:0] rt, logic [CAPIN_W-1:0] ct, bit typed,
                           light_word_t want);
    light_word_t pred;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= rt;
    req_if.capture_time <= ct;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred = step_lights(rt, ct);
    pending_lights.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send(logic [REQ_W-1:0] rt, logic [CAPIN_W-1:0] ct);
    send_item(rt, ct, 1'b0, '0);
  endtask

  task automatic program_regs(logic [15:0] nr, logic [15:0] fr, logic [15:0] fl,
                              logic [15:0] sc);
    logic [15:0]      vals [4];
    logic [IDX_W-1:0] idx;
    vals = '{nr, fr, fl, sc};
    req_if.valid <= 1'b0;
    while (pending_lights.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      idx = IDX_W'(i);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= vals[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      case (idx)
        REG_NEAR:  regs_m.near_threshold    = vals[i][THR_W-1:0];
        REG_FAR:   regs_m.far_threshold     = vals[i][THR_W-1:0];
        REG_FLASH: regs_m.flash_interval_ms = vals[i];
        default:   regs_m.distance_scale    = vals[i];
      endcase
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_measurement();
    logic [CAPIN_W-1:0] rise_c;
    logic [CAPIN_W-1:0] w;
    send(REQ_PERIOD, CAPIN_W'($urandom));
    if ($urandom_range(99) < 20) send(REQ_PERIOD, CAPIN_W'($urandom));
    repeat ($urandom_range(1, 2)) send(REQ_TICK, CAPIN_W'($urandom));
    send(REQ_PERIOD, CAPIN_W'($urandom));
    rise_c = CAPIN_W'($urandom);
    if ($urandom_range(99) < 85) send(REQ_RISE, rise_c);
    else rise_c = '0;
    repeat ($urandom_range(0, 2)) send(REQ_TICK, CAPIN_W'($urandom));
    case ($urandom_range(3))
      0:       w = CAPIN_W'($urandom);
      1:       w = CAPIN_W'($urandom_range(0, 400));
      default: w = CAPIN_W'($urandom_range(0, 6000));
    endcase
    send(REQ_FALL, rise_c + w);
    repeat ($urandom_range(0, 3)) send(REQ_TICK, CAPIN_W'($urandom));
  endtask

  always @(negedge clk) begin
    res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      got_w = '{res_if.light_mode, res_if.red, res_if.green, res_if.blue,
                res_if.range_value, res_if.range_new, res_if.trigger_level,
                res_if.capture_armed};
      if (pending_lights.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) $display("unexpected result word: %s", show(got_w));
      end else begin
        want_w = pending_lights.pop_front();
        if (got_w !== want_w) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("mismatch: expected %s", show(want_w));
            $display("          actual   %s", show(got_w));
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int burst_n;
    int phase_end;
    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_RISE;
    req_if.capture_time = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_NEAR;
    cfg_if.data         = '0;
    bad_words           = 0;
    items_sent          = 0;
    no_idle             = 1'b0;
    regs_m              = '{NEAR_RST, FAR_RST, FLASH_RST, SCALE_RST};
    trig_q              = 1'b0;
    trig_start          = '0;
    ms_cnt              = '0;
    armed_q             = 1'b0;
    rise_t              = '0;
    range_q             = '0;
    mode_q              = MODE_OFF;
    last_flash          = '0;
    flash_ph            = 1'b0;
    lamp                = '0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    dir_rows.push_back('{REQ_RISE,   16'hFFFF, 1'b1, W_IDLE});
    dir_rows.push_back('{REQ_FALL,   16'h0000, 1'b1, W_IDLE});
    dir_rows.push_back('{REQ_TICK,   16'h5A5A, 1'b1, W_IDLE});
    dir_rows.push_back('{REQ_PERIOD, 16'hA5A5, 1'b1, W_TRIG});
    dir_rows.push_back('{REQ_PERIOD, 16'h0000, 1'b1, W_TRIG});
    dir_rows.push_back('{REQ_TICK,   16'hFFFF, 1'b1, W_TRIG});
    dir_rows.push_back('{REQ_PERIOD, 16'h1234, 1'b1, W_ARMED});
    dir_rows.push_back('{REQ_FALL,   16'h0000, 1'b1, W_FAR});
    dir_rows.push_back('{REQ_PERIOD, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_TICK,   16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_PERIOD, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_RISE,   16'd1000, 1'b0, '0});
    dir_rows.push_back('{REQ_FALL,   16'd2000, 1'b0, '0});
    dir_rows.push_back('{REQ_PERIOD, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_TICK,   16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_PERIOD, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_RISE,   16'hFFF0, 1'b0, '0});
    dir_rows.push_back('{REQ_FALL,   16'h0004, 1'b0, '0});
    dir_rows.push_back('{REQ_RISE,   16'hFFFF, 1'b0, '0});
    dir_rows.push_back('{REQ_PERIOD, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_TICK,   16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_PERIOD, 16'h0000, 1'b0, '0});
    dir_rows.push_back('{REQ_RISE,   16'h0005, 1'b0, '0});
    dir_rows.push_back('{REQ_FALL,   16'h0005, 1'b0, '0});
    foreach (dir_rows[i]) send_item(dir_rows[i].rt, dir_rows[i].ct, dir_rows[i].typed,
                                    dir_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(16'(NEAR_RST), 16'(FAR_RST), 16'd3, SCALE_RST);
        1: program_regs(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF);
        2: program_regs(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000);
        3: program_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4)),
                        16'($urandom));
        4: program_regs(16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
        default: begin
          burst_n = $urandom_range(0, 3000);
          program_regs(16'(burst_n), 16'(burst_n + $urandom_range(0, 6000)),
                       16'($urandom_range(0, 6)), 16'($urandom_range(6000, 40000)));
        end
      endcase
      no_idle = (p == 3);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 75) begin
          run_measurement();
        end else begin
          repeat ($urandom_range(1, 3)) send(REQ_W'($urandom_range(0, 3)),
                                             CAPIN_W'($urandom));
        end
      end
      no_idle = 1'b0;
    end

    req_if.valid <= 1'b0;
    while (pending_lights.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (bad_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
